FILE: rtl/clfd_pkg.sv
// Package for the channel length frame deframer.
// Holds parse phase encoding, result kinds and register indexes; no dependencies.
`default_nettype none
package clfd_pkg;

    localparam int unsigned BYTE_W = 8;
    localparam int unsigned LEN_W  = 12;
    localparam int unsigned CH_W   = 4;
    localparam int unsigned CFG_W  = 16;
    localparam int unsigned CFG_IDX_W = 1;

    localparam logic [LEN_W-1:0] LEN_RESET_MAX = 12'hFFF;

    typedef enum logic [2:0] {
        PH_HDR_HI  = 3'b001,
        PH_HDR_LO  = 3'b010,
        PH_PAYLOAD = 3'b100
    } t_phase;

    typedef enum logic {
        KIND_DATA     = 1'b0,
        KIND_OVERSIZE = 1'b1
    } t_kind;

    localparam logic [CFG_IDX_W-1:0] REG_CH_MASK = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_LEN = 1'b1;

endpackage
`default_nettype wire

FILE: rtl/channel_length_frame_deframer_unit.sv
// Top level of the channel length frame deframer.
// Depends on clfd_pkg for the phase encoding, result kinds and register indexes.
//
//  channel | direction | fields                                        | handshake
//  --------+-----------+-----------------------------------------------+------------------
//  rx      | in        | rx_byte                                       | i_valid / o_stall
//  result  | out       | kind, channel, payload_byte, last, frame_len  | o_valid / i_stall
//  config  | in        | index 0 channel mask, 1 max payload length    | i_cfg_we
//
// One byte per cycle while o_stall is low; each request passes through one
// result register, so a result appears the cycle after its byte is taken. The
// input is stalled only while a result is held and the output is stalled. Reset
// (synchronous) returns the parser to the first header byte, mask 0, maximum 4095.
`default_nettype none
module channel_length_frame_deframer_unit
    import clfd_pkg::*;
#(
    parameter int unsigned NUM_CHANNELS = 16
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [CFG_W-1:0]     i_cfg_data,
    input  wire logic                 i_valid,
    output      logic                 o_stall,
    input  wire logic [BYTE_W-1:0]    i_rx_byte,
    output      logic                 o_valid,
    input  wire logic                 i_stall,
    output      logic                 o_kind,
    output      logic [CH_W-1:0]      o_channel,
    output      logic [BYTE_W-1:0]    o_payload_byte,
    output      logic                 o_last,
    output      logic [LEN_W-1:0]     o_frame_length
);

    logic [NUM_CHANNELS-1:0] r_mask;
    logic [LEN_W-1:0]        r_max_len;
    t_phase                  r_phase, n_phase;
    logic [BYTE_W-1:0]       r_hdr_hi, n_hdr_hi;
    logic [CH_W-1:0]         r_cur_ch, n_cur_ch;
    logic [LEN_W-1:0]        r_cur_len, n_cur_len;
    logic [LEN_W-1:0]        r_taken, n_taken;
    logic                    r_discard, n_discard;

    logic                    r_out_valid;
    logic                    r_out_kind, n_out_kind;
    logic [CH_W-1:0]         r_out_ch, n_out_ch;
    logic [BYTE_W-1:0]       r_out_byte, n_out_byte;
    logic                    r_out_last, n_out_last;
    logic [LEN_W-1:0]        r_out_len, n_out_len;
    logic                    n_emit;

    logic                    in_take;
    logic [LEN_W-1:0]        hdr_len;
    logic [CH_W-1:0]         hdr_ch;
    logic [LEN_W-1:0]        taken_inc;
    logic                    ch_on;

    assign o_stall = r_out_valid & i_stall;
    assign in_take = i_valid & ~o_stall;

    assign hdr_ch    = r_hdr_hi[BYTE_W-1 -: CH_W];
    assign hdr_len   = {r_hdr_hi[BYTE_W-CH_W-1:0], i_rx_byte};
    assign taken_inc = r_taken + LEN_W'(1);

    always_comb begin
        ch_on = 1'b0;
        for (int c = 0; c < NUM_CHANNELS; c++) begin
            if (r_cur_ch == CH_W'(c)) begin
                ch_on = r_mask[c];
            end
        end
    end

    always_comb begin
        n_phase    = r_phase;
        n_hdr_hi   = r_hdr_hi;
        n_cur_ch   = r_cur_ch;
        n_cur_len  = r_cur_len;
        n_taken    = r_taken;
        n_discard  = r_discard;
        n_emit     = 1'b0;
        n_out_kind = KIND_DATA;
        n_out_ch   = r_cur_ch;
        n_out_byte = i_rx_byte;
        n_out_last = 1'b0;
        n_out_len  = r_cur_len;
        case (r_phase)
            PH_HDR_LO: begin
                n_cur_ch  = hdr_ch;
                n_cur_len = hdr_len;
                n_taken   = '0;
                n_out_ch  = hdr_ch;
                n_out_len = hdr_len;
                if (hdr_len == '0) begin
                    n_phase   = PH_HDR_HI;
                    n_discard = 1'b0;
                end else begin
                    n_phase   = PH_PAYLOAD;
                    n_discard = hdr_len > r_max_len;
                    if (hdr_len > r_max_len) begin
                        n_emit     = 1'b1;
                        n_out_kind = KIND_OVERSIZE;
                        n_out_byte = '0;
                    end
                end
            end
            PH_PAYLOAD: begin
                n_taken    = taken_inc;
                n_out_last = taken_inc == r_cur_len;
                if (taken_inc == r_cur_len) begin
                    n_phase = PH_HDR_HI;
                    n_taken = '0;
                end
                n_emit = ~r_discard & ch_on;
            end
            default: begin
                n_hdr_hi = i_rx_byte;
                n_phase  = PH_HDR_LO;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask    <= '0;
            r_max_len <= LEN_RESET_MAX;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_CH_MASK: r_mask    <= i_cfg_data[NUM_CHANNELS-1:0];
                REG_MAX_LEN: r_max_len <= i_cfg_data[LEN_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_HDR_HI;
            r_hdr_hi  <= '0;
            r_cur_ch  <= '0;
            r_cur_len <= '0;
            r_taken   <= '0;
            r_discard <= 1'b0;
        end else if (in_take) begin
            r_phase   <= n_phase;
            r_hdr_hi  <= n_hdr_hi;
            r_cur_ch  <= n_cur_ch;
            r_cur_len <= n_cur_len;
            r_taken   <= n_taken;
            r_discard <= n_discard;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (!o_stall) begin
            r_out_valid <= in_take & n_emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_stall) begin
            r_out_kind <= n_out_kind;
            r_out_ch   <= n_out_ch;
            r_out_byte <= n_out_byte;
            r_out_last <= n_out_last;
            r_out_len  <= n_out_len;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_kind         = r_out_kind;
    assign o_channel      = r_out_ch;
    assign o_payload_byte = r_out_byte;
    assign o_last         = r_out_last;
    assign o_frame_length = r_out_len;

endmodule
`default_nettype wire

FILE: rtl/clfd_checker.sv
// Port-level checker for the channel length frame deframer, bound to the top level.
// Depends on clfd_pkg for the byte and length widths and the result kind codes.
`default_nettype none
module clfd_checker
    import clfd_pkg::*;
(
    input wire logic              i_clk,
    input wire logic              i_rst_n,
    input wire logic              i_valid,
    input wire logic              o_stall,
    input wire logic              o_valid,
    input wire logic              i_stall,
    input wire logic              o_kind,
    input wire logic [BYTE_W-1:0] o_payload_byte,
    input wire logic              o_last,
    input wire logic [LEN_W-1:0]  o_frame_length
);

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_payload_byte) && $stable(o_kind))
        else $error("stalled result changed");

    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid && i_stall)
        else $error("input stalled with no held result");

    a_oversize_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_kind == KIND_OVERSIZE |-> o_payload_byte == '0 && !o_last
            && o_frame_length != '0)
        else $error("oversize report carries data");

    a_data_len_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_kind == KIND_DATA |-> o_frame_length != '0)
        else $error("payload byte from zero-length frame");

    a_no_result_without_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid && !i_valid |=> !o_valid)
        else $error("result without request");

endmodule

bind channel_length_frame_deframer_unit clfd_checker u_clfd_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_valid        (i_valid),
    .o_stall        (o_stall),
    .o_valid        (o_valid),
    .i_stall        (i_stall),
    .o_kind         (o_kind),
    .o_payload_byte (o_payload_byte),
    .o_last         (o_last),
    .o_frame_length (o_frame_length)
);
`default_nettype wire

FILE: tb/sv/tb.sv
`timescale 1ns / 1ps
// Testbench for channel_length_frame_deframer_unit: streams framed bytes, predicts each
// delivered byte or oversize report in a scoreboard and checks every result field.
// Depends on clfd_pkg and the deframer RTL only.
module tb;
    import clfd_pkg::*;

    typedef struct packed {
        t_kind             kind;
        logic [CH_W-1:0]   channel;
        logic [BYTE_W-1:0] payload_byte;
        logic              last;
        logic [LEN_W-1:0]  frame_length;
    } t_frame_result;

    typedef enum logic [1:0] {
        ROW_PRED,
        ROW_TYPED,
        ROW_CFG
    } t_row_op;

    typedef struct packed {
        t_row_op              op;
        logic [CFG_IDX_W-1:0] cfg_index;
        logic [CFG_W-1:0]     cfg_data;
        logic [BYTE_W-1:0]    rx_byte;
        logic                 has_res;
        t_frame_result        res;
    } t_stim_row;

    localparam t_frame_result NO_RES = '0;
    localparam int N_DIR = 30;

    t_stim_row dir_rows [0:N_DIR-1] = '{
        '{ROW_TYPED, REG_CH_MASK, 16'h0000, 8'h10, 1'b0, NO_RES},
        '{ROW_TYPED, REG_CH_MASK, 16'h0000, 8'h02, 1'b0, NO_RES},
        '{ROW_TYPED, REG_CH_MASK, 16'h0000, 8'hAB, 1'b0, NO_RES},
        '{ROW_TYPED, REG_CH_MASK, 16'h0000, 8'hCD, 1'b0, NO_RES},
        '{ROW_TYPED, REG_CH_MASK, 16'h0000, 8'hF0, 1'b0, NO_RES},
        '{ROW_TYPED, REG_CH_MASK, 16'h0000, 8'h00, 1'b0, NO_RES},
        '{ROW_CFG,   REG_CH_MASK, 16'hFFFF, 8'h00, 1'b0, NO_RES},
        '{ROW_CFG,   REG_MAX_LEN, 16'd3,    8'h00, 1'b0, NO_RES},
        '{ROW_TYPED, REG_CH_MASK, 16'h0000, 8'h00, 1'b0, NO_RES},
        '{ROW_TYPED, REG_CH_MASK, 16'h0000, 8'h03, 1'b0, NO_RES},
        '{ROW_TYPED, REG_CH_MASK, 16'h0000, 8'h00, 1'b1,
            '{KIND_DATA, 4'h0, 8'h00, 1'b0, 12'd3}},
        '{ROW_TYPED, REG_CH_MASK, 16'h0000, 8'hFF, 1'b1,
            '{KIND_DATA, 4'h0, 8'hFF, 1'b0, 12'd3}},
        '{ROW_TYPED, REG_CH_MASK, 16'h0000, 8'hA5, 1'b1,
            '{KIND_DATA, 4'h0, 8'hA5, 1'b1, 12'd3}},
        '{ROW_TYPED, REG_CH_MASK, 16'h0000, 8'hF0, 1'b0, NO_RES},
        '{ROW_TYPED, REG_CH_MASK, 16'h0000, 8'h04, 1'b1,
            '{KIND_OVERSIZE, 4'hF, 8'h00, 1'b0, 12'd4}},
        '{ROW_TYPED, REG_CH_MASK, 16'h0000, 8'h11, 1'b0, NO_RES},
        '{ROW_TYPED, REG_CH_MASK, 16'h0000, 8'h22, 1'b0, NO_RES},
        '{ROW_TYPED, REG_CH_MASK, 16'h0000, 8'h33, 1'b0, NO_RES},
        '{ROW_TYPED, REG_CH_MASK, 16'h0000, 8'h44, 1'b0, NO_RES},
        '{ROW_CFG,   REG_CH_MASK, 16'h0000, 8'h00, 1'b0, NO_RES},
        '{ROW_CFG,   REG_MAX_LEN, 16'd0,    8'h00, 1'b0, NO_RES},
        '{ROW_TYPED, REG_CH_MASK, 16'h0000, 8'h20, 1'b0, NO_RES},
        '{ROW_TYPED, REG_CH_MASK, 16'h0000, 8'h01, 1'b1,
            '{KIND_OVERSIZE, 4'h2, 8'h00, 1'b0, 12'd1}},
        '{ROW_TYPED, REG_CH_MASK, 16'h0000, 8'h77, 1'b0, NO_RES},
        '{ROW_CFG,   REG_CH_MASK, 16'h8001, 8'h00, 1'b0, NO_RES},
        '{ROW_CFG,   REG_MAX_LEN, 16'h0FFF, 8'h00, 1'b0, NO_RES},
        '{ROW_PRED,  REG_CH_MASK, 16'h0000, 8'hF0, 1'b0, NO_RES},
        '{ROW_PRED,  REG_CH_MASK, 16'h0000, 8'h02, 1'b0, NO_RES},
        '{ROW_PRED,  REG_CH_MASK, 16'h0000, 8'h5A, 1'b0, NO_RES},
        '{ROW_PRED,  REG_CH_MASK, 16'h0000, 8'hC3, 1'b0, NO_RES}
    };

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = REG_CH_MASK;
    logic [CFG_W-1:0]     i_cfg_data = '0;
    logic                 i_valid = 1'b0;
    logic                 o_stall;
    logic [BYTE_W-1:0]    i_rx_byte = '0;
    logic                 o_valid;
    logic                 i_stall = 1'b0;
    logic                 o_kind;
    logic [CH_W-1:0]      o_channel;
    logic [BYTE_W-1:0]    o_payload_byte;
    logic                 o_last;
    logic [LEN_W-1:0]     o_frame_length;

    // deframer mirror: settings and parser state
    logic [CFG_W-1:0]  ch_mask = '0;
    logic [LEN_W-1:0]  max_len = LEN_RESET_MAX;
    t_phase            parse_ph = PH_HDR_HI;
    logic [BYTE_W-1:0] hdr_hi = '0;
    logic [CH_W-1:0]   cur_ch = '0;
    logic [LEN_W-1:0]  cur_len = '0;
    logic [LEN_W-1:0]  taken = '0;
    logic              dropping = 1'b0;

    t_frame_result frame_results_due [$];
    int            mismatches = 0;
    int            bytes_sent = 0;
    int            burst_left = 0;
    logic [15:0]   stall_cycle = '0;

    channel_length_frame_deframer_unit uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_rx_byte      (i_rx_byte),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_kind         (o_kind),
        .o_channel      (o_channel),
        .o_payload_byte (o_payload_byte),
        .o_last         (o_last),
        .o_frame_length (o_frame_length)
    );

    always #5 i_clk = ~i_clk;

    function automatic bit deframe_byte(input logic [BYTE_W-1:0] b, output t_frame_result r);
        logic [15:0] hdr;
        logic        at_end;
        r = NO_RES;
        deframe_byte = 1'b0;
        case (parse_ph)
            PH_HDR_LO: begin
                hdr = {hdr_hi, b};
                cur_ch = hdr[15:12];
                cur_len = hdr[LEN_W-1:0];
                taken = '0;
                if (cur_len == '0) begin
                    parse_ph = PH_HDR_HI;
                    dropping = 1'b0;
                end else begin
                    parse_ph = PH_PAYLOAD;
                    dropping = (cur_len > max_len);
                    if (dropping) begin
                        r.kind = KIND_OVERSIZE;
                        r.channel = cur_ch;
                        r.frame_length = cur_len;
                        deframe_byte = 1'b1;
                    end
                end
            end
            PH_PAYLOAD: begin
                taken = taken + LEN_W'(1);
                at_end = (taken == cur_len);
                if (at_end) begin
                    parse_ph = PH_HDR_HI;
                    taken = '0;
                end
                if (!dropping && ch_mask[cur_ch]) begin
                    r.kind = KIND_DATA;
                    r.channel = cur_ch;
                    r.payload_byte = b;
                    r.last = at_end;
                    r.frame_length = cur_len;
                    deframe_byte = 1'b1;
                end
            end
            default: begin
                hdr_hi = b;
                parse_ph = PH_HDR_LO;
            end
        endcase
    endfunction

    task automatic send_request(input logic [BYTE_W-1:0] b, input bit typed,
                                input bit t_has, input t_frame_result t_res);
        t_frame_result pred;
        bit            has;
        @(negedge i_clk);
        if (burst_left == 0) begin
            i_valid = 1'b0;
            repeat ($urandom_range(1, 5)) @(negedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(64, 256)
                                                      : $urandom_range(1, 12);
        end
        i_valid = 1'b1;
        i_rx_byte = b;
        do @(posedge i_clk); while (o_stall);
        burst_left--;
        bytes_sent++;
        has = deframe_byte(b, pred);
        if (typed) begin
            has = t_has;
            pred = t_res;
        end
        if (has)
            frame_results_due.push_back(pred);
    endtask

    task automatic send_byte(input logic [BYTE_W-1:0] b);
        send_request(b, 1'b0, 1'b0, NO_RES);
    endtask

    // drop valid, drain every result, then give the result register time to clear
    task automatic settle();
        @(negedge i_clk);
        i_valid = 1'b0;
        while (frame_results_due.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we = 1'b1;
        i_cfg_index = idx;
        i_cfg_data = data;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        if (idx == REG_CH_MASK)
            ch_mask = data;
        else
            max_len = data[LEN_W-1:0];
    endtask

    // complete a header or payload left open by noise or a truncated frame
    task automatic finish_open_frame();
        int rem;
        if (parse_ph == PH_HDR_LO) begin
            send_byte(8'($urandom_range(0, 31)));
        end else if (parse_ph == PH_PAYLOAD) begin
            rem = int'(cur_len) - int'(taken);
            repeat (rem) send_byte(8'($urandom_range(0, 255)));
        end
    endtask

    task automatic check_field(input string name, input logic [15:0] want, input logic [15:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
            mismatches++;
        end
    endtask

    always @(negedge i_clk) begin
        stall_cycle <= stall_cycle + 16'd1;
        case (stall_cycle[9:8])
            2'd0: i_stall <= 1'b0;
            2'd1: i_stall <= ($urandom_range(0, 1) == 1);
            2'd2: i_stall <= (stall_cycle[2:0] < 3'd3);
            default: i_stall <= ($urandom_range(0, 7) != 0);
        endcase
    end

    always @(posedge i_clk) begin : result_check
        t_frame_result want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (frame_results_due.size() == 0) begin
                $display("%0t: unexpected result: expected none, %s %0b %0h %0h %0b %0d",
                         $time, "actual kind/ch/byte/last/len", o_kind, o_channel,
                         o_payload_byte, o_last, o_frame_length);
                mismatches++;
            end else begin
                want = frame_results_due.pop_front();
                check_field("kind", 16'(want.kind), 16'(o_kind));
                check_field("channel", 16'(want.channel), 16'(o_channel));
                check_field("payload_byte", 16'(want.payload_byte), 16'(o_payload_byte));
                check_field("last", 16'(want.last), 16'(o_last));
                check_field("frame_length", 16'(want.frame_length), 16'(o_frame_length));
            end
        end
    end

    initial begin : stimulus
        int          target;
        int          r;
        int          lenv;
        int          count;
        logic [CH_W-1:0]  ch;
        logic [CFG_W-1:0] mask_val;
        logic [LEN_W-1:0] max_val;

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (dir_rows[i]) begin
            if (dir_rows[i].op == ROW_CFG) begin
                settle();
                write_reg(dir_rows[i].cfg_index, dir_rows[i].cfg_data);
            end else begin
                send_request(dir_rows[i].rx_byte, dir_rows[i].op == ROW_TYPED,
                             dir_rows[i].has_res, dir_rows[i].res);
            end
        end

        for (int ph = 0; ph < 8; ph++) begin
            settle();
            case (ph)
                0: begin mask_val = 16'hFFFF; max_val = 12'hFFF; end
                1: begin mask_val = 16'h0000; max_val = 12'd8;   end
                2: begin mask_val = 16'($urandom); max_val = 12'd1; end
                3: begin mask_val = 16'hFFFF; max_val = 12'd0;   end
                default: begin
                    mask_val = ($urandom_range(0, 1) == 1) ? 16'hFFFF : 16'($urandom);
                    max_val = ($urandom_range(0, 2) == 0) ? 12'hFFF
                                                          : 12'($urandom_range(1, 16));
                end
            endcase
            write_reg(REG_CH_MASK, mask_val);
            write_reg(REG_MAX_LEN, {{(CFG_W-LEN_W){1'b0}}, max_val});

            target = bytes_sent + 75;
            while (bytes_sent < target) begin
                if (parse_ph != PH_HDR_HI) begin
                    finish_open_frame();
                end else begin
                    r = $urandom_range(0, 99);
                    ch = 4'($urandom_range(0, 15));
                    if (r < 8) begin
                        send_byte({ch, 4'h0});
                        send_byte(8'h00);
                    end else if (r < 16) begin
                        // stray byte: misalign the parser onto a short bogus frame
                        send_byte({ch, 4'h0});
                    end else begin
                        lenv = $urandom_range(1, 16);
                        if (max_len != '0 && max_len <= 12'd64 && r < 35)
                            lenv = int'(max_len) + $urandom_range(0, 1);
                        if ($urandom_range(0, 63) == 0)
                            lenv = $urandom_range(17, 300);
                        count = (r >= 90) ? $urandom_range(0, (lenv > 16 ? 16 : lenv) - 1)
                                          : lenv;
                        send_byte({ch, 4'(lenv >> 8)});
                        send_byte(8'(lenv));
                        repeat (count) send_byte(8'($urandom_range(0, 255)));
                    end
                end
            end
            while (parse_ph != PH_HDR_HI) finish_open_frame();
        end

        settle();
        repeat (8) @(negedge i_clk);
        if (mismatches == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

    initial begin
        #10_000_000;
        $display("tb NOT OK");
        $finish;
    end

endmodule

FILE: files.f
rtl/clfd_pkg.sv
rtl/channel_length_frame_deframer_unit.sv
rtl/clfd_checker.sv
tb/sv/tb.sv
